// ===== sv/gcrw_pkg.sv =====
// ----------------------------------------------------------------------------
// gcrw_pkg: shared types and arithmetic helpers
// Request/result payloads, the wide fixed-point value type and its saturating
// helpers, used across the ghost cell datapath.
// ----------------------------------------------------------------------------
package gcrw_pkg;

	localparam int VAL_W   = 63;  // signed working value, held within +-(2^62-1)
	localparam int MAG_W   = 62;  // magnitude of a working value
	localparam int DENS_W  = 31;
	localparam int MOM_W   = 32;
	localparam int ENER_W  = 31;
	localparam int HR_W    = 19;
	localparam int OUT_W   = 32;
	localparam int MUL_LAT = 4;

	localparam logic [HR_W-1:0] HR_RESET = 19'd91750;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [MAG_W-1:0] mag_t;

	localparam mag_t LIM_MAG = '1;
	localparam val_t LIM     = {1'b0, LIM_MAG};
	localparam val_t OUT_MAX = val_t'(64'sd2147483647);
	localparam val_t OUT_MIN = val_t'(-64'sd2147483648);

	typedef struct packed {
		logic                     is_ghost;
		logic                     use_x_side;
		logic                     use_y_side;
		logic [DENS_W-1:0]        x_density;
		logic signed [MOM_W-1:0]  x_momentum_x;
		logic signed [MOM_W-1:0]  x_momentum_y;
		logic [ENER_W-1:0]        x_energy;
		logic [DENS_W-1:0]        y_density;
		logic signed [MOM_W-1:0]  y_momentum_x;
		logic signed [MOM_W-1:0]  y_momentum_y;
		logic [ENER_W-1:0]        y_energy;
	} req_t;

	typedef struct packed {
		logic                     written;
		logic [DENS_W-1:0]        ghost_density;
		logic signed [OUT_W-1:0]  ghost_momentum_x;
		logic signed [OUT_W-1:0]  ghost_momentum_y;
		logic signed [OUT_W-1:0]  ghost_energy;
	} rsp_t;

	function automatic mag_t mag_of(val_t a);
		val_t n;
		n = a[VAL_W-1] ? -a : a;
		return n[MAG_W-1:0];
	endfunction

	function automatic val_t sat_add(val_t a, val_t b);
		logic signed [VAL_W:0] s;
		logic signed [VAL_W:0] lim_e;
		lim_e = {2'b00, LIM_MAG};
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (s > lim_e)
			return LIM;
		else if (s < -lim_e)
			return -LIM;
		else
			return s[VAL_W-1:0];
	endfunction

	// halve, truncating toward zero
	function automatic val_t half(val_t a);
		val_t inc;
		inc = val_t'(a[VAL_W-1]);
		return (a + inc) >>> 1;
	endfunction

	function automatic logic [OUT_W-1:0] out32(val_t x);
		logic [OUT_W-1:0] r;
		if (x > OUT_MAX)
			r = OUT_MAX[OUT_W-1:0];
		else if (x < OUT_MIN)
			r = OUT_MIN[OUT_W-1:0];
		else
			r = x[OUT_W-1:0];
		return r;
	endfunction

endpackage

// ===== sv/gcrw_dly.sv =====
// ----------------------------------------------------------------------------
// gcrw_dly: fixed delay line
// Shift register that keeps side data aligned with the arithmetic pipelines.
// ----------------------------------------------------------------------------
module gcrw_dly #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] tap_s [0:DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				tap_s[i] <= '0;
		end else begin
			tap_s[0] <= d;
			for (int i = 1; i < DEPTH; i++)
				tap_s[i] <= tap_s[i-1];
		end
	end

	assign q = tap_s[DEPTH-1];

endmodule

// ===== sv/gcrw_mul.sv =====
// ----------------------------------------------------------------------------
// gcrw_mul: pipelined saturating fixed-point multiplier
// (a*b) >> FRAC_BITS on sign-magnitude operands, four 31x31 partial
// products, saturated to the working range.
// ----------------------------------------------------------------------------
module gcrw_mul import gcrw_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  val_t a,
	input  val_t b,
	output val_t p
);

	localparam int HALF_W = MAG_W / 2;
	localparam int PP_W   = 2 * HALF_W;
	localparam int PROD_W = 2 * MAG_W;

	mag_t              ma_s1, mb_s1;
	logic              neg_s1, neg_s2, neg_s3;
	logic [PP_W-1:0]   pp_ll_s2, pp_lh_s2, pp_hl_s2, pp_hh_s2;
	logic [PROD_W-1:0] prod_s3;
	logic [PROD_W-1:0] shifted;
	mag_t              mag_res;
	val_t              val_res;
	val_t              p_s4;

	always_comb begin
		shifted = prod_s3 >> FRAC_BITS;
		mag_res = (|shifted[PROD_W-1:MAG_W]) ? LIM_MAG : shifted[MAG_W-1:0];
		val_res = val_t'({1'b0, mag_res});
	end

	always_ff @(posedge clk) begin
		ma_s1    <= mag_of(a);
		mb_s1    <= mag_of(b);
		neg_s1   <= a[VAL_W-1] ^ b[VAL_W-1];

		pp_ll_s2 <= ma_s1[HALF_W-1:0] * mb_s1[HALF_W-1:0];
		pp_lh_s2 <= ma_s1[HALF_W-1:0] * mb_s1[MAG_W-1:HALF_W];
		pp_hl_s2 <= ma_s1[MAG_W-1:HALF_W] * mb_s1[HALF_W-1:0];
		pp_hh_s2 <= ma_s1[MAG_W-1:HALF_W] * mb_s1[MAG_W-1:HALF_W];
		neg_s2   <= neg_s1;

		prod_s3  <= PROD_W'(pp_ll_s2)
			+ ((PROD_W'(pp_lh_s2) + PROD_W'(pp_hl_s2)) << HALF_W)
			+ (PROD_W'(pp_hh_s2) << MAG_W);
		neg_s3   <= neg_s2;

		p_s4     <= neg_s3 ? -val_res : val_res;
	end

	assign p = p_s4;

endmodule

// ===== sv/gcrw_div.sv =====
// ----------------------------------------------------------------------------
// gcrw_div: pipelined fixed-point divider
// (|num| << FRAC_BITS) / |den|, one restoring step per stage, signed and
// saturated at the end. Zero divisor gives zero.
// ----------------------------------------------------------------------------
module gcrw_div import gcrw_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int NUM_W     = 32,
	parameter int DEN_W     = 31
) (
	input  logic clk,
	input  val_t num,
	input  val_t den,
	output val_t q
);

	localparam int Q_W   = NUM_W + FRAC_BITS;
	localparam int EXT_W = (Q_W > MAG_W) ? Q_W : MAG_W;

	logic [Q_W-1:0]   dvd_s  [0:Q_W];
	logic [Q_W-1:0]   quo_s  [0:Q_W];
	logic [DEN_W-1:0] rem_s  [0:Q_W];
	logic [DEN_W-1:0] den_s  [0:Q_W];
	logic             neg_s  [0:Q_W];
	logic             zero_s [0:Q_W];

	logic [DEN_W:0]   trial  [0:Q_W-1];
	logic [DEN_W:0]   diff   [0:Q_W-1];
	logic [Q_W-1:0]   ge;

	mag_t             num_m, den_m, mag_res;
	logic [EXT_W-1:0] q_ext;
	val_t             val_res;
	val_t             q_q;

	assign num_m = mag_of(num);
	assign den_m = mag_of(den);

	always_comb begin
		for (int k = 0; k < Q_W; k++) begin
			trial[k] = {rem_s[k], dvd_s[k][Q_W-1]};
			diff[k]  = trial[k] - {1'b0, den_s[k]};
			ge[k]    = trial[k] >= {1'b0, den_s[k]};
		end
	end

	always_comb begin
		q_ext   = EXT_W'(quo_s[Q_W]);
		mag_res = (q_ext > EXT_W'(LIM_MAG)) ? LIM_MAG : q_ext[MAG_W-1:0];
		val_res = val_t'({1'b0, mag_res});
	end

	always_ff @(posedge clk) begin
		dvd_s[0]  <= {num_m[NUM_W-1:0], {FRAC_BITS{1'b0}}};
		quo_s[0]  <= '0;
		rem_s[0]  <= '0;
		den_s[0]  <= den_m[DEN_W-1:0];
		neg_s[0]  <= num[VAL_W-1] ^ den[VAL_W-1];
		zero_s[0] <= (den_m == '0);
		for (int k = 0; k < Q_W; k++) begin
			rem_s[k+1]  <= ge[k] ? diff[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
			dvd_s[k+1]  <= dvd_s[k] << 1;
			quo_s[k+1]  <= {quo_s[k][Q_W-2:0], ge[k]};
			den_s[k+1]  <= den_s[k];
			neg_s[k+1]  <= neg_s[k];
			zero_s[k+1] <= zero_s[k];
		end
		if (zero_s[Q_W])
			q_q <= '0;
		else
			q_q <= neg_s[Q_W] ? -val_res : val_res;
	end

	assign q = q_q;

endmodule

// ===== sv/gcrw_side.sv =====
// ----------------------------------------------------------------------------
// gcrw_side: conserved-to-primitive conversion for one mirror neighbor
// u = mx/rho, v = my/rho, p = (gamma-1)*(E - rho*(u*u+v*v)/2), all aligned
// at the outputs.
// ----------------------------------------------------------------------------
module gcrw_side import gcrw_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [DENS_W-1:0]       rho,
	input  logic signed [MOM_W-1:0] mom_x,
	input  logic signed [MOM_W-1:0] mom_y,
	input  logic [ENER_W-1:0]       ener,
	input  val_t                    gm1,
	output logic [DENS_W-1:0]       rho_out,
	output val_t                    u_out,
	output val_t                    v_out,
	output val_t                    p_out
);

	localparam int DIV_LAT = MOM_W + FRAC_BITS + 2;

	val_t              u, v, uu, vv, kin_full, excess;
	logic [DENS_W-1:0] rho_k;
	logic [ENER_W-1:0] ener_k;

	gcrw_div #(.FRAC_BITS(FRAC_BITS), .NUM_W(MOM_W), .DEN_W(DENS_W)) u_div_u (
		.clk(clk), .num(val_t'(mom_x)), .den(val_t'(rho)), .q(u));
	gcrw_div #(.FRAC_BITS(FRAC_BITS), .NUM_W(MOM_W), .DEN_W(DENS_W)) u_div_v (
		.clk(clk), .num(val_t'(mom_y)), .den(val_t'(rho)), .q(v));

	gcrw_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_uu (.clk(clk), .a(u), .b(u), .p(uu));
	gcrw_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_vv (.clk(clk), .a(v), .b(v), .p(vv));

	gcrw_dly #(.WIDTH(DENS_W), .DEPTH(DIV_LAT + MUL_LAT)) u_dly_rho_k (
		.clk(clk), .arst_n(arst_n), .d(rho), .q(rho_k));

	gcrw_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_kin (
		.clk(clk), .a(val_t'(rho_k)), .b(sat_add(uu, vv)), .p(kin_full));

	gcrw_dly #(.WIDTH(ENER_W), .DEPTH(DIV_LAT + 2 * MUL_LAT)) u_dly_ener (
		.clk(clk), .arst_n(arst_n), .d(ener), .q(ener_k));

	assign excess = sat_add(val_t'(ener_k), -half(kin_full));

	gcrw_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_p (.clk(clk), .a(gm1), .b(excess), .p(p_out));

	gcrw_dly #(.WIDTH(VAL_W), .DEPTH(3 * MUL_LAT)) u_dly_u (
		.clk(clk), .arst_n(arst_n), .d(u), .q(u_out));
	gcrw_dly #(.WIDTH(VAL_W), .DEPTH(3 * MUL_LAT)) u_dly_v (
		.clk(clk), .arst_n(arst_n), .d(v), .q(v_out));
	gcrw_dly #(.WIDTH(DENS_W), .DEPTH(2 * MUL_LAT)) u_dly_rho_o (
		.clk(clk), .arst_n(arst_n), .d(rho_k), .q(rho_out));

endmodule

// ===== sv/ghost_cell_reflective_wall_state.sv =====
// ----------------------------------------------------------------------------
// ghost_cell_reflective_wall_state: reflective wall ghost cell state
// Builds the conserved state of a ghost cell from its x and y mirror
// neighbors, with the wall-normal velocity mirrored.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle without exception: busy is
// never raised, and every request leaves as exactly one result, flagged by
// done for a single cycle; the receiver cannot hold results back. The
// latency is set by the two bit-per-stage dividers in series: the velocity
// division (32+FRAC_BITS+2 stages) and the division of pressure by gamma-1
// (62+FRAC_BITS+2 stages), plus three multiplier passes of four stages
// each. heat_ratio (gamma, unsigned Q.FRAC_BITS) is written through
// cfg_we/cfg_wdata and must only change while no request is in flight.
// Results that are not ghost cells, or have no neighbor, carry written = 0
// and all-zero fields.
// ----------------------------------------------------------------------------
module ghost_cell_reflective_wall_state import gcrw_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  req_t            request,
	output logic            done,
	output rsp_t            result,
	input  logic            cfg_we,
	input  logic [HR_W-1:0] cfg_wdata
);

	localparam int SIDE_LAT    = MOM_W + FRAC_BITS + 2 + 3 * MUL_LAT;
	localparam int FIN_DIV_LAT = MAG_W + FRAC_BITS + 2;
	localparam int GM_W        = (FRAC_BITS + 1 > HR_W) ? FRAC_BITS + 1 : HR_W;

	// configuration
	logic [HR_W-1:0] heat_ratio_q;
	val_t            gm1;

	// side outputs
	logic [DENS_W-1:0] rx, ry;
	val_t              ux, vx, px, uy, vy, py;
	logic [3:0]        flags_d;

	// merge stage
	logic [DENS_W:0]   rho_sum;
	logic [DENS_W-1:0] rho_c;
	val_t              u_c, v_c, p_c;
	logic              vld_s1, wr_s1;
	logic [DENS_W-1:0] rho_s1;
	val_t              u_s1, v_s1, p_s1;

	// final conversion
	val_t              mx, my, uu2, vv2, kin2, p_div;
	val_t              mx_d, my_d, kin2_d;
	logic [DENS_W-1:0] rho_k, rho_d;
	logic [1:0]        ctl_d;

	// never stall: every cycle can take a request
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			heat_ratio_q <= HR_RESET;
		else if (cfg_we)
			heat_ratio_q <= cfg_wdata;
	end

	assign gm1 = val_t'({1'b0, heat_ratio_q}) - (val_t'(1) <<< FRAC_BITS);

	// Convert both neighbors in parallel; the flags decide later which count.
	gcrw_side #(.FRAC_BITS(FRAC_BITS)) u_side_x (
		.clk(clk), .arst_n(arst_n),
		.rho(request.x_density), .mom_x(request.x_momentum_x),
		.mom_y(request.x_momentum_y), .ener(request.x_energy), .gm1(gm1),
		.rho_out(rx), .u_out(ux), .v_out(vx), .p_out(px));

	gcrw_side #(.FRAC_BITS(FRAC_BITS)) u_side_y (
		.clk(clk), .arst_n(arst_n),
		.rho(request.y_density), .mom_x(request.y_momentum_x),
		.mom_y(request.y_momentum_y), .ener(request.y_energy), .gm1(gm1),
		.rho_out(ry), .u_out(uy), .v_out(vy), .p_out(py));

	// Carry the request valid and its flags alongside the side pipelines.
	gcrw_dly #(.WIDTH(4), .DEPTH(SIDE_LAT)) u_dly_flags (
		.clk(clk), .arst_n(arst_n),
		.d({start & ~busy, request.is_ghost, request.use_x_side, request.use_y_side}),
		.q(flags_d));

	// Merge: mirror the wall-normal velocity (u from the x side, v from the
	// y side), then average when both neighbors exist.
	always_comb begin
		rho_sum = {1'b0, rx} + {1'b0, ry};
		if (flags_d[1] && flags_d[0]) begin
			rho_c = rho_sum[DENS_W:1];
			u_c   = half(sat_add(-ux, uy));
			v_c   = half(sat_add(vx, -vy));
			p_c   = half(sat_add(px, py));
		end else if (flags_d[1]) begin
			rho_c = rx;
			u_c   = -ux;
			v_c   = vx;
			p_c   = px;
		end else begin
			rho_c = ry;
			u_c   = uy;
			v_c   = -vy;
			p_c   = py;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			wr_s1  <= 1'b0;
		end else begin
			vld_s1 <= flags_d[3];
			wr_s1  <= flags_d[3] & flags_d[2] & (flags_d[1] | flags_d[0]);
		end
	end

	always_ff @(posedge clk) begin
		rho_s1 <= rho_c;
		u_s1   <= u_c;
		v_s1   <= v_c;
		p_s1   <= p_c;
	end

	// Back to conserved form: momenta, kinetic energy and p/(gamma-1).
	gcrw_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_mx (
		.clk(clk), .a(val_t'(rho_s1)), .b(u_s1), .p(mx));
	gcrw_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_my (
		.clk(clk), .a(val_t'(rho_s1)), .b(v_s1), .p(my));
	gcrw_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_uu (.clk(clk), .a(u_s1), .b(u_s1), .p(uu2));
	gcrw_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_vv (.clk(clk), .a(v_s1), .b(v_s1), .p(vv2));

	gcrw_dly #(.WIDTH(DENS_W), .DEPTH(MUL_LAT)) u_dly_rho_k (
		.clk(clk), .arst_n(arst_n), .d(rho_s1), .q(rho_k));

	gcrw_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_kin (
		.clk(clk), .a(val_t'(rho_k)), .b(sat_add(uu2, vv2)), .p(kin2));

	gcrw_div #(.FRAC_BITS(FRAC_BITS), .NUM_W(MAG_W), .DEN_W(GM_W)) u_div_p (
		.clk(clk), .num(p_s1), .den(gm1), .q(p_div));

	// Hold the faster paths until the pressure division lands.
	gcrw_dly #(.WIDTH(VAL_W), .DEPTH(FIN_DIV_LAT - MUL_LAT)) u_dly_mx (
		.clk(clk), .arst_n(arst_n), .d(mx), .q(mx_d));
	gcrw_dly #(.WIDTH(VAL_W), .DEPTH(FIN_DIV_LAT - MUL_LAT)) u_dly_my (
		.clk(clk), .arst_n(arst_n), .d(my), .q(my_d));
	gcrw_dly #(.WIDTH(VAL_W), .DEPTH(FIN_DIV_LAT - 2 * MUL_LAT)) u_dly_kin (
		.clk(clk), .arst_n(arst_n), .d(kin2), .q(kin2_d));
	gcrw_dly #(.WIDTH(DENS_W), .DEPTH(FIN_DIV_LAT - MUL_LAT)) u_dly_rho (
		.clk(clk), .arst_n(arst_n), .d(rho_k), .q(rho_d));
	gcrw_dly #(.WIDTH(2), .DEPTH(FIN_DIV_LAT)) u_dly_ctl (
		.clk(clk), .arst_n(arst_n), .d({vld_s1, wr_s1}), .q(ctl_d));

	// Output register: zero every field when nothing was written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done   <= 1'b0;
			result <= '0;
		end else begin
			done           <= ctl_d[1];
			result.written <= ctl_d[0];
			if (ctl_d[0]) begin
				result.ghost_density    <= rho_d;
				result.ghost_momentum_x <= out32(mx_d);
				result.ghost_momentum_y <= out32(my_d);
				result.ghost_energy     <= out32(sat_add(p_div, half(kin2_d)));
			end else begin
				result.ghost_density    <= '0;
				result.ghost_momentum_x <= '0;
				result.ghost_momentum_y <= '0;
				result.ghost_energy     <= '0;
			end
		end
	end

	a_unwritten_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.written |-> result.ghost_density == '0
			&& result.ghost_momentum_x == '0 && result.ghost_momentum_y == '0
			&& result.ghost_energy == '0)
		else $error("unwritten result carries nonzero fields");

	a_written_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.written |-> done)
		else $error("written flag raised without result strobe");

	a_merge_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ##(FIN_DIV_LAT + 1) done)
		else $error("merged request did not reach the output");

endmodule
